[rtl/core/oaf_pkg.sv]
package oaf_pkg;

    // Field geometry
    localparam int VALUE_W   = 36;
    localparam int LEN_W     = 4;
    localparam int LAYOUT_W  = 3;
    localparam int CHAR_W    = 8;
    localparam int NUM_DIGITS = VALUE_W / 3;
    localparam int DEF_MAX_FIELD = 12;

    // Descriptor queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    typedef enum logic [LAYOUT_W-1:0] {
        LAYOUT_RIGHT      = 3'd0,  // right-justified, space padded
        LAYOUT_SP_NUL     = 3'd1,  // digits, space, NUL
        LAYOUT_SP         = 3'd2,  // digits, space
        LAYOUT_NUL_SP     = 3'd3,  // digits, NUL, space
        LAYOUT_NUL        = 3'd4,  // digits, NUL
        LAYOUT_LEFT       = 3'd5,  // left-adjusted, NUL fill
        LAYOUT_ZERO_PAD   = 3'd6,  // right-justified, '0' padded
        LAYOUT_LEFT_ALT   = 3'd7   // same as LAYOUT_LEFT
    } t_layout;

    // One classified field, ready for character generation
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [LEN_W-1:0]   len;        // effective field length, >= 1
        logic [LEN_W-1:0]   anchor;     // positions below this hold digits or pad
        logic [LEN_W-1:0]   put;        // number of digits actually written
        logic [CHAR_W-1:0]  pad_char;
        logic [CHAR_W-1:0]  last_char;  // char at len-1 when past anchor
        logic [CHAR_W-1:0]  prev_char;  // char at len-2 when past anchor
        logic               ovf;
    } t_desc;

    function automatic logic [2:0] oct_digit(input logic [VALUE_W-1:0] v,
                                             input logic [LEN_W-1:0] k);
        logic [2:0] d;
        d = 3'd0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (k == LEN_W'(i)) begin
                d = v[3*i +: 3];
            end
        end
        return d;
    endfunction

endpackage

[rtl/core/octal_ascii_field_formatter_unit.sv]
// Octal ASCII field formatter. Each input transaction carries an unsigned
// 36-bit value, a field length and a layout code; the block answers with one
// output transaction per character of the field, first position first, with
// o_last on the final character and o_overflow on that same character when
// the digits (or trailers) did not fit. Layouts 0..4 right-justify the octal
// digits in spaces, 1..4 after reserving trailing space/NUL characters; 6 pads
// with '0'; 5 and 7 left-adjust and fill with NUL. When digits do not fit, the
// high digits are dropped. A length above MAX_FIELD is clipped to MAX_FIELD; a
// length of zero is accepted and produces nothing. Throughput: one character
// per clock on the output channel while the receiver does not stall, set by
// the back end's single-character output register; a field has 1 to 12
// characters by default. Fields follow each other back to back when the next
// one is already queued. The front end takes a new transaction every cycle
// while the 2-entry descriptor queue has room; the field being emitted stays
// in the queue until its last character, so input stalls only when one field
// is already waiting behind it. When idle, an accepted field is written into
// the descriptor queue and its first character then into the output register.
// No state survives between fields; reset only clears the control logic.
module octal_ascii_field_formatter_unit
    import oaf_pkg::*;
#(
    parameter int MAX_FIELD = DEF_MAX_FIELD
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [LEN_W-1:0]    i_field_len,
    input  logic [LAYOUT_W-1:0] i_layout,

    // output channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [CHAR_W-1:0]   o_char_out,
    output logic                o_last,
    output logic                o_overflow
);

    t_desc front_desc;
    t_desc head_desc;
    logic  front_keep;
    logic  q_full;
    logic  q_nonempty;
    logic  q_pop;
    logic  q_push;

    // Classify: digit count, justification anchor, trailers, overflow.
    oaf_front #(
        .MAX_FIELD (MAX_FIELD)
    ) u_front (
        .i_value     (i_value),
        .i_field_len (i_field_len),
        .i_layout    (i_layout),
        .o_desc      (front_desc),
        .o_keep      (front_keep)
    );

    assign o_stall = q_full;
    // zero-length fields are consumed without queuing anything
    assign q_push  = i_valid && !q_full && front_keep;

    oaf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_desc     (front_desc),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_desc     (head_desc)
    );

    // Walk the head descriptor one character per cycle while the receiver does not stall.
    oaf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_nonempty),
        .i_head       (head_desc),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_char_out   (o_char_out),
        .o_last       (o_last),
        .o_overflow   (o_overflow)
    );

endmodule

[rtl/core/oaf_front.sv]
module oaf_front
    import oaf_pkg::*;
#(
    parameter int MAX_FIELD = DEF_MAX_FIELD
) (
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [LEN_W-1:0]    i_field_len,
    input  logic [LAYOUT_W-1:0] i_layout,
    output t_desc               o_desc,
    output logic                o_keep
);

    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  nd;
    logic [LEN_W-1:0]  trail;
    logic [LEN_W-1:0]  region;
    logic [LEN_W-1:0]  anchor;
    logic              right;
    logic              left;
    logic [CHAR_W-1:0] last_char;
    logic [CHAR_W-1:0] prev_char;
    logic [CHAR_W-1:0] pad_char;
    t_layout           mode;

    assign mode = t_layout'(i_layout);

    // saturate length
    always_comb begin
        if (int'(i_field_len) > MAX_FIELD) begin
            len = LEN_W'(MAX_FIELD);
        end else begin
            len = i_field_len;
        end
    end

    assign o_keep = (len != '0);

    // digit count: highest nonzero octal digit, at least one
    always_comb begin
        nd = LEN_W'(1);
        for (int k = 1; k < NUM_DIGITS; k++) begin
            if ((i_value >> (3 * k)) != '0) begin
                nd = LEN_W'(k + 1);
            end
        end
    end

    always_comb begin
        trail     = '0;
        right     = 1'b0;
        left      = 1'b0;
        last_char = CH_NUL;
        prev_char = CH_NUL;
        pad_char  = CH_SPACE;
        unique case (mode)
            LAYOUT_RIGHT: begin
                right = 1'b1;
            end
            LAYOUT_SP_NUL: begin
                right = 1'b1;
                trail = LEN_W'(2);
                prev_char = CH_SPACE;
            end
            LAYOUT_SP: begin
                right = 1'b1;
                trail = LEN_W'(1);
                last_char = CH_SPACE;
            end
            LAYOUT_NUL_SP: begin
                right = 1'b1;
                trail = LEN_W'(2);
                last_char = CH_SPACE;
            end
            LAYOUT_NUL: begin
                right = 1'b1;
                trail = LEN_W'(1);
            end
            LAYOUT_ZERO_PAD: begin
                pad_char = CH_ZERO;
            end
            LAYOUT_LEFT, LAYOUT_LEFT_ALT: begin
                left = 1'b1;
            end
            default: begin
                left = 1'b1;
            end
        endcase
    end

    assign region = (trail > len) ? '0 : (len - trail);

    always_comb begin
        if (right) begin
            anchor = region;
        end else if (left && (nd <= len)) begin
            anchor = nd;
        end else begin
            anchor = len;
        end
    end

    assign o_desc.value     = i_value;
    assign o_desc.len       = len;
    assign o_desc.anchor    = anchor;
    assign o_desc.put       = (nd < anchor) ? nd : anchor;
    assign o_desc.pad_char  = pad_char;
    assign o_desc.last_char = last_char;
    assign o_desc.prev_char = prev_char;
    assign o_desc.ovf       = right ? ((trail > len) || (nd > region)) : (nd > len);

endmodule

[rtl/core/oaf_queue.sv]
module oaf_queue
    import oaf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_nonempty,
    output t_desc o_desc
);

    t_desc               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count,  n_count;

    assign o_full     = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_desc     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count above depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_nonempty))
        else $error("pop from empty queue");

endmodule

[rtl/core/oaf_back.sv]
module oaf_back
    import oaf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  t_desc             i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CHAR_W-1:0] o_char_out,
    output logic              o_last,
    output logic              o_overflow
);

    logic               r_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic               r_ovf;
    logic [LEN_W-1:0]   r_pos, n_pos;

    logic               adv;
    logic               fire;
    logic               is_last;
    logic               in_digits;
    logic [LEN_W-1:0]   k;
    logic [CHAR_W-1:0]  ch;

    assign adv       = !r_valid || !i_stall;
    assign fire      = adv && i_head_valid;
    assign is_last   = (r_pos == (i_head.len - LEN_W'(1)));
    assign in_digits = (r_pos < i_head.anchor);
    assign k         = i_head.anchor - LEN_W'(1) - r_pos;
    assign o_pop     = fire && is_last;
    assign n_pos     = is_last ? '0 : r_pos + LEN_W'(1);

    always_comb begin
        if (in_digits) begin
            if (k < i_head.put) begin
                ch = CH_ZERO + {5'd0, oct_digit(i_head.value, k)};
            end else begin
                ch = i_head.pad_char;
            end
        end else if (is_last) begin
            ch = i_head.last_char;
        end else begin
            ch = i_head.prev_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else if (fire) begin
            r_valid <= 1'b1;
            r_pos   <= n_pos;
        end else if (adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_char <= ch;
            r_last <= is_last;
            r_ovf  <= is_last && i_head.ovf;
        end
    end

    assign o_valid    = r_valid;
    assign o_char_out = r_char;
    assign o_last     = r_last;
    assign o_overflow = r_ovf;

    a_ovf_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_ovf |-> r_last)
        else $error("overflow flagged on a non-final character");

    a_pos_in_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (r_pos < i_head.len))
        else $error("character position beyond field length");

    a_pos_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> (r_pos == '0))
        else $error("position counter not rewound between fields");

endmodule

[tb/sv/oaf_field_sb_pkg.sv]
`timescale 1ns / 1ps
package oaf_field_sb_pkg;
    import oaf_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              ovf;
    } field_char_t;

    class field_scoreboard;
        field_char_t pending_chars[$];
        int unsigned n_errors;
        int unsigned n_fields;
        int unsigned n_empty;
        int unsigned n_chars;
        int unsigned n_ovf;
        int unsigned layout_hits[8];

        function new();
            n_errors = 0;
            n_fields = 0;
            n_empty  = 0;
            n_chars  = 0;
            n_ovf    = 0;
            foreach (layout_hits[i]) layout_hits[i] = 0;
        endfunction

        function logic [CHAR_W-1:0] octal_char(logic [VALUE_W-1:0] value, int k);
            return CH_ZERO + CHAR_W'((value >> (3 * k)) & VALUE_W'(7));
        endfunction

        // Builds the expected characters of one accepted field.
        function void note_field(logic [VALUE_W-1:0] value, logic [LEN_W-1:0] len_in,
                                 logic [LAYOUT_W-1:0] layout);
            logic [CHAR_W-1:0] chars [DEF_MAX_FIELD];
            logic [CHAR_W-1:0] trailer [2];
            int len;
            int ntrail;
            int region;
            int ndig;
            int put;
            logic ovf;
            field_char_t fc;

            n_fields++;
            layout_hits[layout]++;
            len = (len_in > DEF_MAX_FIELD) ? DEF_MAX_FIELD : int'(len_in);
            if (len == 0) begin
                n_empty++;
                return;
            end

            ndig = 1;
            for (int k = 1; k < NUM_DIGITS; k++) begin
                if ((value >> (3 * k)) != 0) ndig = k + 1;
            end

            ovf = 1'b0;
            ntrail = 0;
            trailer[0] = CH_NUL;
            trailer[1] = CH_NUL;

            if (layout == LAYOUT_LEFT || layout == LAYOUT_LEFT_ALT) begin
                // low digits kept when too many; they then fill the field
                for (int i = 0; i < len; i++) chars[i] = CH_NUL;
                ovf = (ndig > len);
                put = ovf ? len : ndig;
                for (int k = 0; k < put; k++) chars[put - 1 - k] = octal_char(value, k);
            end else if (layout == LAYOUT_ZERO_PAD) begin
                for (int i = 0; i < len; i++) chars[i] = CH_ZERO;
                ovf = (ndig > len);
                put = ovf ? len : ndig;
                for (int k = 0; k < put; k++) chars[len - 1 - k] = octal_char(value, k);
            end else begin
                if (layout == LAYOUT_SP_NUL) begin
                    trailer[0] = CH_SPACE;
                    trailer[1] = CH_NUL;
                    ntrail = 2;
                end else if (layout == LAYOUT_SP) begin
                    trailer[0] = CH_SPACE;
                    ntrail = 1;
                end else if (layout == LAYOUT_NUL_SP) begin
                    trailer[0] = CH_NUL;
                    trailer[1] = CH_SPACE;
                    ntrail = 2;
                end else if (layout == LAYOUT_NUL) begin
                    trailer[0] = CH_NUL;
                    ntrail = 1;
                end

                if (ntrail > len) begin
                    // only the final trailer survives
                    ovf = 1'b1;
                    for (int i = 0; i < len; i++) chars[i] = trailer[ntrail - len + i];
                    region = 0;
                end else begin
                    region = len - ntrail;
                    for (int i = 0; i < ntrail; i++) chars[region + i] = trailer[i];
                end
                for (int i = 0; i < region; i++) chars[i] = CH_SPACE;
                if (ndig > region) ovf = 1'b1;
                put = (ndig < region) ? ndig : region;
                for (int k = 0; k < put; k++) chars[region - 1 - k] = octal_char(value, k);
            end

            for (int i = 0; i < len; i++) begin
                fc.ch   = chars[i];
                fc.last = (i == len - 1);
                fc.ovf  = (i == len - 1) && ovf;
                pending_chars.push_back(fc);
            end
        endfunction

        task report(string msg);
            if (n_errors < 40) $display("ERROR: %s", msg);
            n_errors++;
        endtask

        task check_char(logic [CHAR_W-1:0] ch, logic last, logic ovf);
            field_char_t want;
            if (pending_chars.size() == 0) begin
                report($sformatf("unexpected char 0x%02h last=%0b ovf=%0b", ch, last, ovf));
                return;
            end
            want = pending_chars.pop_front();
            n_chars++;
            if (last && ovf) n_ovf++;
            if (ch !== want.ch)
                report($sformatf("char 0x%02h, expected 0x%02h", ch, want.ch));
            if (last !== want.last)
                report($sformatf("last %0b, expected %0b (char 0x%02h)", last, want.last,
                                 want.ch));
            if (ovf !== want.ovf)
                report($sformatf("overflow %0b, expected %0b (char 0x%02h)", ovf, want.ovf,
                                 want.ch));
        endtask
    endclass

endpackage

[tb/sv/octal_ascii_field_formatter_unit_tb.sv]
`timescale 1ns / 1ps
module octal_ascii_field_formatter_unit_tb;
    import oaf_pkg::*;
    import oaf_field_sb_pkg::*;

    // Worst case is ~430 fields x 12 chars, each char possibly held by a receiver
    // stall burst; the limit leaves a wide margin.
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 30;     // quiet tail after the last field
    localparam int HOLD_CYCLES = 90;     // long receiver hold-off

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic [VALUE_W-1:0]  i_value     = '0;
    logic [LEN_W-1:0]    i_field_len = '0;
    logic [LAYOUT_W-1:0] i_layout    = '0;
    logic                i_stall     = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [CHAR_W-1:0]   o_char_out;
    logic                o_last;
    logic                o_overflow;

    // pacing controls for the sender and the receiver, set by the main sequence
    bit tx_gaps_on  = 1'b1;
    bit rx_gaps_on  = 1'b1;
    bit rx_hold_req = 1'b0;

    int unsigned cycle_count = 0;
    field_scoreboard sb;

    octal_ascii_field_formatter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .i_field_len (i_field_len),
        .i_layout    (i_layout),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_out  (o_char_out),
        .o_last      (o_last),
        .o_overflow  (o_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d chars still pending", cycle_count,
                     sb.pending_chars.size());
            $display("octal_ascii_field_formatter_unit_tb failed");
            $finish;
        end
    end

    // Output monitor. All DUT outputs are read right after the edge, before
    // any nonblocking update lands, so they hold the values the edge saw.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_char(o_char_out, o_last, o_overflow);
        end
    end

    // Receiver pacing. Either a requested long hold-off (counted here, while
    // the sender keeps offering), random stall bursts of random length, or
    // ready. Exactly one nonblocking write of i_stall per loop edge.
    initial begin : rx_pacing
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                rx_hold_req = 1'b0;
            end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Offers one field and returns at the edge that accepts it. The payload
    // holds steady while stalled. A random idle burst may follow; with no
    // burst, valid stays high into the next transaction.
    task automatic send_field(input logic [VALUE_W-1:0] value,
                              input logic [LEN_W-1:0] len,
                              input logic [LAYOUT_W-1:0] layout);
        i_valid     <= 1'b1;
        i_value     <= value;
        i_field_len <= len;
        i_layout    <= layout;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_field(value, len, layout);
        if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // Sender pause: nothing offered until every expected char has come back.
    task automatic wait_all_chars();
        i_valid <= 1'b0;
        while (sb.pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // Random fields. Values get a random octal digit count so that short and
    // long numbers meet short and long fields (lots of overflow both ways).
    // Lengths mostly 1..12; one in ten anywhere in 0..15 to hit the empty
    // field and the clipping above the maximum. Empty fields do not count.
    task automatic random_fields(input int count);
        logic [63:0]         raw;
        logic [VALUE_W-1:0]  value;
        logic [VALUE_W-1:0]  mask;
        logic [LEN_W-1:0]    len;
        int                  ndig;
        int                  n_sent;
        n_sent = 0;
        while (n_sent < count) begin
            raw  = {$urandom(), $urandom()};
            ndig = $urandom_range(1, NUM_DIGITS);
            mask = (VALUE_W'(1) << (3 * ndig)) - VALUE_W'(1);
            value = raw[VALUE_W-1:0];
            if ($urandom_range(0, 7) != 0) value = value & mask;
            if ($urandom_range(0, 15) == 0) value = '0;
            if ($urandom_range(0, 9) == 0) begin
                len = LEN_W'($urandom_range(0, 15));
            end else begin
                len = LEN_W'($urandom_range(1, DEF_MAX_FIELD));
            end
            send_field(value, len, LAYOUT_W'($urandom_range(0, 7)));
            if (len != 0) n_sent++;
        end
    endtask

    // Directed corners: widest value, zero, every layout, trailers that do
    // not fit, no room left for digits, empty and over-long fields, left
    // overflow, and alternating bit patterns.
    task automatic directed_fields();
        send_field(36'd0,            4'd1,  LAYOUT_RIGHT);
        send_field(36'hF_FFFF_FFFF,  4'd12, LAYOUT_RIGHT);
        send_field(36'hF_FFFF_FFFF,  4'd12, LAYOUT_SP_NUL);
        send_field(36'd0,            4'd1,  LAYOUT_SP_NUL);
        send_field(36'd0,            4'd1,  LAYOUT_NUL_SP);
        send_field(36'd0,            4'd2,  LAYOUT_SP_NUL);
        send_field(36'd0,            4'd2,  LAYOUT_NUL_SP);
        send_field(36'd0,            4'd1,  LAYOUT_SP);
        send_field(36'd0,            4'd1,  LAYOUT_NUL);
        send_field(36'd5,            4'd0,  LAYOUT_RIGHT);
        send_field(36'o1234,         4'd15, LAYOUT_RIGHT);
        send_field(36'o777,          4'd12, LAYOUT_LEFT);
        send_field(36'o12345670,     4'd4,  LAYOUT_LEFT);
        send_field(36'o12345670,     4'd3,  LAYOUT_LEFT_ALT);
        send_field(36'o7654,         4'd12, LAYOUT_ZERO_PAD);
        send_field(36'hF_FFFF_FFFF,  4'd5,  LAYOUT_ZERO_PAD);
        send_field(36'o1234,         4'd8,  LAYOUT_NUL_SP);
        send_field(36'o1234,         4'd8,  LAYOUT_SP);
        send_field(36'o1234,         4'd8,  LAYOUT_NUL);
        send_field(36'o1234,         4'd13, LAYOUT_LEFT_ALT);
        send_field(36'h5_5555_5555,  4'd14, LAYOUT_SP_NUL);
        send_field(36'hA_AAAA_AAAA,  4'd12, LAYOUT_ZERO_PAD);
        send_field(36'o7,            4'd3,  LAYOUT_SP);
    endtask

    initial begin : main_seq
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_fields();
        wait_all_chars();

        // random traffic with idling on both sides
        random_fields(140);

        // Back-pressure: receiver holds off for a long stretch while the
        // sender offers back to back, so the descriptor queue fills and the
        // input stalls. Then the sender waits for everything to drain.
        tx_gaps_on  = 1'b0;
        rx_hold_req = 1'b1;
        random_fields(10);
        wait_all_chars();
        tx_gaps_on = 1'b1;

        random_fields(140);
        wait_all_chars();

        // last stretch at full rate, no idling anywhere
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        random_fields(100);
        wait_all_chars();

        // anything arriving now is unexpected and gets flagged by the monitor
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d fields accepted (%0d empty), %0d chars checked, %0d overflow flags",
                 sb.n_fields, sb.n_empty, sb.n_chars, sb.n_ovf);
        $display("fields per layout 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.layout_hits[0], sb.layout_hits[1], sb.layout_hits[2],
                 sb.layout_hits[3], sb.layout_hits[4], sb.layout_hits[5],
                 sb.layout_hits[6], sb.layout_hits[7]);
        if (sb.n_errors == 0) begin
            $display("octal_ascii_field_formatter_unit_tb passed");
        end else begin
            $display("%0d mismatches", sb.n_errors);
            $display("octal_ascii_field_formatter_unit_tb failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/oaf_pkg.sv
rtl/core/oaf_front.sv
rtl/core/oaf_queue.sv
rtl/core/oaf_back.sv
rtl/core/octal_ascii_field_formatter_unit.sv
tb/sv/oaf_field_sb_pkg.sv
tb/sv/octal_ascii_field_formatter_unit_tb.sv
